### rtl/core/uoi_pkg.sv
// Shared types, constants and tables for the unicycle odometry integrator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package uoi_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam int DT_W   = 22;
  localparam int CFG_W  = 32;
  localparam int POS_W  = 48;
  localparam int ANG_W  = 32;
  localparam int Q_W    = 32;
  localparam int IDX_W  = 2;
  localparam int DIST_W = 34;
  localparam int MA_W   = 33;
  localparam int MB_W   = 27;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 67;
  localparam int P_W    = 55;
  localparam int DPOS_W = 37;
  localparam int CW_W   = 34;

  localparam logic [IDX_W-1:0] REG_LINEAR_SPEED = 2'd0;
  localparam logic [IDX_W-1:0] REG_TURN_RATE    = 2'd1;

  localparam logic [CFG_W-1:0] LINEAR_SPEED_RST = 32'd13107;
  localparam logic [CFG_W-1:0] TURN_RATE_RST    = 32'd0;

  localparam logic signed [CW_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW_W-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [MB_W-1:0]        TURN_SCALE  = 27'd42722830;

  localparam logic signed [POS_W+1:0] POS_MAX = 50'sd140737488355327;
  localparam logic signed [POS_W+1:0] POS_MIN = -50'sd140737488355328;

  // multiplier operand selections
  localparam logic [2:0] MUL_SPD_DT  = 3'd0;
  localparam logic [2:0] MUL_TURN_DT = 3'd1;
  localparam logic [2:0] MUL_PL_K    = 3'd2;
  localparam logic [2:0] MUL_PH_K    = 3'd3;
  localparam logic [2:0] MUL_C_DL    = 3'd4;
  localparam logic [2:0] MUL_C_DH    = 3'd5;
  localparam logic [2:0] MUL_S_DL    = 3'd6;
  localparam logic [2:0] MUL_S_DH    = 3'd7;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_SH27  = 2'd2;
  localparam logic [1:0] ACC_SH17  = 2'd3;

  typedef struct packed {
    logic       ld_dt;
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic       cap_d;
    logic       cap_p;
    logic       cap_step;
    logic       upd_x;
    logic       upd_y;
    logic       upd_head;
    logic       ld_out;
    logic       cordic_start;
    logic       cordic_new;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic cordic_done;
  } status_t;

  // arctangent of 2^-i as a binary angle
  function automatic logic [ANG_W-1:0] atan_bam(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/uoi_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of a binary angle, Q2.30.
// Depends on uoi_pkg.
`timescale 1ns / 1ps
module uoi_cordic #(
  parameter int STEPS = uoi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [uoi_pkg::ANG_W-1:0]         angle,
  output logic                              done,
  output logic signed [uoi_pkg::Q_W-1:0]    sin_out,
  output logic signed [uoi_pkg::Q_W-1:0]    cos_out
);
  import uoi_pkg::*;

  localparam int CNT_W = $clog2(STEPS + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   flip_r, flip_nxt;
  logic signed [CW_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;

  logic [ANG_W-1:0]       rot, red;
  logic                   flip;
  logic signed [CW_W-1:0] xs, ys, at, xf, yf;

  // quadrant fold: angles in the left half plane are rotated by a half turn
  always_comb begin
    rot  = angle - 32'h4000_0000;
    flip = ~rot[ANG_W-1];
    red  = flip ? (angle - 32'h8000_0000) : angle;
  end

  // one micro-rotation per cycle
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = signed'({2'b00, atan_bam(5'(cnt_r))});
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    flip_nxt = flip_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      flip_nxt = flip;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = CW_W'(signed'(red));
    end else if (busy_r) begin
      if (cnt_r == CNT_W'(STEPS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (!z_r[CW_W-1]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  // undo the fold and clamp to unit magnitude
  always_comb begin
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    if (xf > ONE_Q30)       cos_out = Q_W'(ONE_Q30);
    else if (xf < -ONE_Q30) cos_out = Q_W'(-ONE_Q30);
    else                    cos_out = Q_W'(xf);
    if (yf > ONE_Q30)       sin_out = Q_W'(ONE_Q30);
    else if (yf < -ONE_Q30) sin_out = Q_W'(-ONE_Q30);
    else                    sin_out = Q_W'(yf);
  end

  assign done = done_r;

endmodule

### rtl/core/uoi_datapath.sv
// Datapath: config registers, shared multiplier and accumulator, pose state,
// CORDIC unit and output register. Depends on uoi_pkg and uoi_cordic.
`timescale 1ns / 1ps
module uoi_datapath #(
  parameter int CORDIC_STEPS = uoi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  uoi_pkg::cmd_t                     cmd,
  output uoi_pkg::status_t                  status,
  input  logic [uoi_pkg::DT_W-1:0]          in_elapsed_time,
  input  logic                              cfg_we,
  input  logic [uoi_pkg::IDX_W-1:0]         cfg_index,
  input  logic [uoi_pkg::CFG_W-1:0]         cfg_data,
  output logic signed [uoi_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [uoi_pkg::POS_W-1:0]  out_pos_y,
  output logic [uoi_pkg::ANG_W-1:0]         out_heading,
  output logic signed [uoi_pkg::Q_W-1:0]    out_quat_z,
  output logic signed [uoi_pkg::Q_W-1:0]    out_quat_w
);
  import uoi_pkg::*;

  logic [CFG_W-1:0]         speed_r, turn_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DIST_W-1:0] d_r;
  logic signed [P_W-1:0]    p_r;
  logic [ANG_W-1:0]         step_r;
  logic signed [POS_W-1:0]  x_r, y_r;
  logic [ANG_W-1:0]         head_r, head_new;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     cdone;
  logic signed [Q_W-1:0]    c_sin, c_cos;
  logic [ANG_W-1:0]         c_angle;

  logic signed [PROD_W-1:0] d_rnd;
  logic [63:0]              step_rnd;
  logic signed [ACC_W-1:0]  pos_rnd;
  logic signed [DPOS_W-1:0] dpos;
  logic signed [POS_W+1:0]  sum_pos, sat_pos;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= LINEAR_SPEED_RST;
      turn_r  <= TURN_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINEAR_SPEED: speed_r <= cfg_data;
        REG_TURN_RATE:    turn_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier operand selection
  always_comb begin
    case (cmd.mul_sel)
      MUL_SPD_DT:  begin
        mul_a = MA_W'(signed'(speed_r));
        mul_b = signed'(MB_W'(dt_r));
      end
      MUL_TURN_DT: begin
        mul_a = MA_W'(signed'(turn_r));
        mul_b = signed'(MB_W'(dt_r));
      end
      MUL_PL_K:    begin
        mul_a = signed'(MA_W'(p_r[26:0]));
        mul_b = signed'(TURN_SCALE);
      end
      MUL_PH_K:    begin
        mul_a = MA_W'(signed'(p_r[P_W-1:27]));
        mul_b = signed'(TURN_SCALE);
      end
      MUL_C_DL:    begin
        mul_a = MA_W'(c_cos);
        mul_b = signed'(MB_W'(d_r[16:0]));
      end
      MUL_C_DH:    begin
        mul_a = MA_W'(c_cos);
        mul_b = MB_W'(signed'(d_r[DIST_W-1:17]));
      end
      MUL_S_DL:    begin
        mul_a = MA_W'(c_sin);
        mul_b = signed'(MB_W'(d_r[16:0]));
      end
      default:     begin
        mul_a = MA_W'(c_sin);
        mul_b = MB_W'(signed'(d_r[DIST_W-1:17]));
      end
    endcase
  end

  // accumulator of partial products
  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD: acc_nxt = ACC_W'(prod_r);
      ACC_SH27: acc_nxt = acc_r + (ACC_W'(prod_r) <<< 27);
      ACC_SH17: acc_nxt = acc_r + (ACC_W'(prod_r) <<< 17);
      default:  acc_nxt = acc_r;
    endcase
  end

  // rounding and saturation
  always_comb begin
    d_rnd    = prod_r + PROD_W'(64'sd524288);
    step_rnd = acc_r[63:0] + 64'h8000_0000;
    pos_rnd  = acc_r + ACC_W'(64'sd536870912);
    dpos     = pos_rnd[ACC_W-1:30];
    sum_pos  = (cmd.upd_x ? (POS_W+2)'(x_r) : (POS_W+2)'(y_r)) + (POS_W+2)'(dpos);
    if (sum_pos > POS_MAX)      sat_pos = POS_MAX;
    else if (sum_pos < POS_MIN) sat_pos = POS_MIN;
    else                        sat_pos = sum_pos;
    head_new = head_r + step_r;
    c_angle  = cmd.cordic_new ? (head_new >> 1) : head_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    if (cmd.ld_dt)    dt_r   <= in_elapsed_time;
    if (cmd.cap_d)    d_r    <= d_rnd[DIST_W+19:20];
    if (cmd.cap_p)    p_r    <= prod_r[P_W-1:0];
    if (cmd.cap_step) step_r <= step_rnd[63:32];
  end

  // pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      head_r <= '0;
    end else begin
      if (cmd.upd_x)    x_r    <= sat_pos[POS_W-1:0];
      if (cmd.upd_y)    y_r    <= sat_pos[POS_W-1:0];
      if (cmd.upd_head) head_r <= head_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_pos_x   <= x_r;
      out_pos_y   <= y_r;
      out_heading <= head_r;
      out_quat_z  <= c_sin;
      out_quat_w  <= c_cos;
    end
  end

  uoi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.cordic_start),
    .angle   (c_angle),
    .done    (cdone),
    .sin_out (c_sin),
    .cos_out (c_cos)
  );

  assign status.dt_zero     = (in_elapsed_time == '0);
  assign status.cordic_done = cdone;

endmodule

### rtl/core/uoi_ctrl.sv
// Sequencer for one tick: multiplies, CORDIC runs and result handoff.
// Depends on uoi_pkg.
`timescale 1ns / 1ps
module uoi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  uoi_pkg::status_t  status,
  output uoi_pkg::cmd_t     cmd
);
  import uoi_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_D = 4'd1;
  localparam logic [3:0] S_CAP_D = 4'd2;
  localparam logic [3:0] S_CAP_P = 4'd3;
  localparam logic [3:0] S_HMUL  = 4'd4;
  localparam logic [3:0] S_HACC1 = 4'd5;
  localparam logic [3:0] S_HACC2 = 4'd6;
  localparam logic [3:0] S_STEP  = 4'd7;
  localparam logic [3:0] S_WAIT1 = 4'd8;
  localparam logic [3:0] S_X1    = 4'd9;
  localparam logic [3:0] S_X2    = 4'd10;
  localparam logic [3:0] S_X3    = 4'd11;
  localparam logic [3:0] S_Y1    = 4'd12;
  localparam logic [3:0] S_Y2    = 4'd13;
  localparam logic [3:0] S_Y3    = 4'd14;
  localparam logic [3:0] S_WAIT2 = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // state sequencing and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_SPD_DT;
    cmd.acc_op  = ACC_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !status.dt_zero) begin
          cmd.ld_dt        = 1'b1;
          cmd.cordic_start = 1'b1;
          state_nxt        = S_MUL_D;
        end
      end
      S_MUL_D: begin
        cmd.mul_sel = MUL_SPD_DT;
        state_nxt   = S_CAP_D;
      end
      S_CAP_D: begin
        cmd.cap_d   = 1'b1;
        cmd.mul_sel = MUL_TURN_DT;
        state_nxt   = S_CAP_P;
      end
      S_CAP_P: begin
        cmd.cap_p = 1'b1;
        state_nxt = S_HMUL;
      end
      S_HMUL: begin
        cmd.mul_sel = MUL_PL_K;
        state_nxt   = S_HACC1;
      end
      S_HACC1: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MUL_PH_K;
        state_nxt   = S_HACC2;
      end
      S_HACC2: begin
        cmd.acc_op = ACC_SH27;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        cmd.cap_step = 1'b1;
        state_nxt    = S_WAIT1;
      end
      S_WAIT1: begin
        cmd.mul_sel = MUL_C_DL;
        if (status.cordic_done) state_nxt = S_X1;
      end
      S_X1: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MUL_C_DH;
        state_nxt   = S_X2;
      end
      S_X2: begin
        cmd.acc_op = ACC_SH17;
        state_nxt  = S_X3;
      end
      S_X3: begin
        cmd.upd_x   = 1'b1;
        cmd.mul_sel = MUL_S_DL;
        state_nxt   = S_Y1;
      end
      S_Y1: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MUL_S_DH;
        state_nxt   = S_Y2;
      end
      S_Y2: begin
        cmd.acc_op = ACC_SH17;
        state_nxt  = S_Y3;
      end
      S_Y3: begin
        cmd.upd_y        = 1'b1;
        cmd.upd_head     = 1'b1;
        cmd.cordic_start = 1'b1;
        cmd.cordic_new   = 1'b1;
        state_nxt        = S_WAIT2;
      end
      S_WAIT2: begin
        if (status.cordic_done && out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out)      out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !status.dt_zero |=> state_r == S_MUL_D)
    else $error("accepted tick did not start the sequence");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.upd_x, cmd.upd_y, cmd.ld_out, cmd.cap_d, cmd.cap_step}))
    else $error("conflicting datapath strobes");

endmodule

### rtl/core/unicycle_odometry_integrator.sv
// Top level of the unicycle odometry integrator: controller plus datapath.
// Depends on uoi_pkg, uoi_ctrl, uoi_datapath (and uoi_cordic below it).
`timescale 1ns / 1ps
// Dead-reckoning integrator for a unicycle model. Each input item is a tick
// carrying the elapsed time in 2^-20 s; a zero tick is consumed with no
// result. Otherwise position advances by speed*dt along the old heading, the
// heading advances by turn_rate*dt, and one item with x, y, heading and the
// yaw quaternion (z, w) follows. The single iterative CORDIC unit runs once
// on the old heading and once on the new half heading; one tick is in flight
// at a time. Configuration writes are taken in any cycle (ready is always
// high) and belong to idle periods.
module unicycle_odometry_integrator #(
  parameter int CORDIC_STEPS = uoi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [uoi_pkg::DT_W-1:0]          in_elapsed_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [uoi_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [uoi_pkg::POS_W-1:0]  out_pos_y,
  output logic [uoi_pkg::ANG_W-1:0]         out_heading,
  output logic signed [uoi_pkg::Q_W-1:0]    out_quat_z,
  output logic signed [uoi_pkg::Q_W-1:0]    out_quat_w,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [uoi_pkg::IDX_W-1:0]         cfg_index,
  input  logic [uoi_pkg::CFG_W-1:0]         cfg_data
);
  import uoi_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  uoi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  uoi_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_elapsed_time (in_elapsed_time),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_heading     (out_heading),
    .out_quat_z      (out_quat_z),
    .out_quat_w      (out_quat_w)
  );

endmodule
